@@ hw/rtl/crd_pkg.sv @@
`default_nettype none

package crd_pkg;

   // FNV-1a 64-bit offset basis and record magic
   localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
   localparam logic [31:0] REC_MAGIC  = 32'h52564334;

   // parse phases, one-hot
   typedef enum logic [13:0] {
      PH_MAGIC   = 14'h0001,
      PH_KEYLEN  = 14'h0002,
      PH_KEY     = 14'h0004,
      PH_STATUS  = 14'h0008,
      PH_TIMES   = 14'h0010,
      PH_HCOUNT  = 14'h0020,
      PH_NAMELEN = 14'h0040,
      PH_NAME    = 14'h0080,
      PH_VALLEN  = 14'h0100,
      PH_VALUE   = 14'h0200,
      PH_BODYLEN = 14'h0400,
      PH_BODY    = 14'h0800,
      PH_TRAILER = 14'h1000,
      PH_AFTER   = 14'h2000
   } phase_type;

   // error codes
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_MAGIC = 3'd1;
   localparam logic [2:0] ERR_SHORT = 3'd2;
   localparam logic [2:0] ERR_SUM   = 3'd3;
   localparam logic [2:0] ERR_TRAIL = 3'd4;

   // region tags
   localparam logic [2:0] RGN_FIXED  = 3'd0;
   localparam logic [2:0] RGN_KEY    = 3'd1;
   localparam logic [2:0] RGN_NAME   = 3'd2;
   localparam logic [2:0] RGN_VALUE  = 3'd3;
   localparam logic [2:0] RGN_BODY   = 3'd4;
   localparam logic [2:0] RGN_SUM    = 3'd5;
   localparam logic [2:0] RGN_IGNORE = 3'd6;

   // one result item
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [2:0]  region;
      logic        record_done;
      logic        record_ok;
      logic [2:0]  fault_code;
      logic [15:0] http_status;
      logic [63:0] stored_at;
      logic [63:0] initial_age;
      logic [63:0] expires_at;
      logic [63:0] stale_while_revalidate;
      logic [63:0] stale_if_error;
      logic [31:0] header_count;
   } result_type;

   // one FNV-1a step; prime 2^40 + 0x1b3 done as shifts and adds
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crd_parse.sv @@
`default_nettype none

module crd_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   output crd_pkg::result_type     result
);

   crd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [63:0] shift_ff, shift_in;
   logic [63:0] left_ff, left_in;
   logic [31:0] hdrs_ff, hdrs_in;
   logic [2:0]  tidx_ff, tidx_in;
   logic [63:0] hash_ff, hash_in;
   logic [2:0]  err_ff, err_in;
   logic [15:0] status_ff, status_in;
   logic [63:0] stored_ff, stored_in;
   logic [63:0] age_ff, age_in;
   logic [63:0] expires_ff, expires_in;
   logic [63:0] swr_ff, swr_in;
   logic [63:0] sie_ff, sie_in;
   logic [31:0] hcount_ff, hcount_in;

   logic [63:0] acc;
   logic [2:0]  last_idx;
   logic [2:0]  region;
   logic [2:0]  err_final;

   always_comb begin
      phase_in   = phase_ff;
      bif_in     = bif_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      hdrs_in    = hdrs_ff;
      tidx_in    = tidx_ff;
      hash_in    = hash_ff;
      err_in     = err_ff;
      status_in  = status_ff;
      stored_in  = stored_ff;
      age_in     = age_ff;
      expires_in = expires_ff;
      swr_in     = swr_ff;
      sie_in     = sie_ff;
      hcount_in  = hcount_ff;
      region     = crd_pkg::RGN_FIXED;
      acc        = shift_ff | ({56'd0, in_byte} << {bif_ff, 3'b000});

      if (phase_ff == crd_pkg::PH_STATUS) begin
         last_idx = 3'd1;
      end else if (phase_ff == crd_pkg::PH_TIMES || phase_ff == crd_pkg::PH_BODYLEN ||
                   phase_ff == crd_pkg::PH_TRAILER) begin
         last_idx = 3'd7;
      end else begin
         last_idx = 3'd3;
      end

      if (err_ff != crd_pkg::ERR_NONE) begin
         region = crd_pkg::RGN_IGNORE;
      end else if (phase_ff == crd_pkg::PH_AFTER) begin
         region = crd_pkg::RGN_IGNORE;
         err_in = crd_pkg::ERR_TRAIL;
      end else if (phase_ff == crd_pkg::PH_KEY || phase_ff == crd_pkg::PH_NAME ||
                   phase_ff == crd_pkg::PH_VALUE || phase_ff == crd_pkg::PH_BODY) begin
         // counted payload bytes
         hash_in = crd_pkg::fnv_step(hash_ff, in_byte);
         left_in = left_ff - 64'd1;
         unique case (phase_ff)
            crd_pkg::PH_KEY: begin
               region = crd_pkg::RGN_KEY;
               if (left_ff == 64'd1) phase_in = crd_pkg::PH_STATUS;
            end
            crd_pkg::PH_NAME: begin
               region = crd_pkg::RGN_NAME;
               if (left_ff == 64'd1) phase_in = crd_pkg::PH_VALLEN;
            end
            crd_pkg::PH_VALUE: begin
               region = crd_pkg::RGN_VALUE;
               if (left_ff == 64'd1) begin
                  hdrs_in  = hdrs_ff - 32'd1;
                  phase_in = (hdrs_ff != 32'd1) ? crd_pkg::PH_NAMELEN : crd_pkg::PH_BODYLEN;
               end
            end
            default: begin
               region = crd_pkg::RGN_BODY;
               if (left_ff == 64'd1) phase_in = crd_pkg::PH_TRAILER;
            end
         endcase
      end else begin
         // fixed-width little-endian fields
         if (phase_ff == crd_pkg::PH_TRAILER) begin
            region = crd_pkg::RGN_SUM;
         end else begin
            hash_in = crd_pkg::fnv_step(hash_ff, in_byte);
         end
         if (bif_ff != last_idx) begin
            bif_in   = bif_ff + 3'd1;
            shift_in = acc;
         end else begin
            bif_in   = 3'd0;
            shift_in = 64'd0;
            unique case (phase_ff)
               crd_pkg::PH_MAGIC: begin
                  if (acc[31:0] != crd_pkg::REC_MAGIC) err_in = crd_pkg::ERR_MAGIC;
                  else phase_in = crd_pkg::PH_KEYLEN;
               end
               crd_pkg::PH_KEYLEN: begin
                  left_in  = {32'd0, acc[31:0]};
                  phase_in = (acc[31:0] != 32'd0) ? crd_pkg::PH_KEY : crd_pkg::PH_STATUS;
               end
               crd_pkg::PH_STATUS: begin
                  status_in = acc[15:0];
                  tidx_in   = 3'd0;
                  phase_in  = crd_pkg::PH_TIMES;
               end
               crd_pkg::PH_TIMES: begin
                  unique case (tidx_ff)
                     3'd0:    stored_in  = acc;
                     3'd1:    age_in     = acc;
                     3'd2:    expires_in = acc;
                     3'd3:    swr_in     = acc;
                     default: sie_in     = acc;
                  endcase
                  if (tidx_ff >= 3'd4) begin
                     tidx_in  = 3'd0;
                     phase_in = crd_pkg::PH_HCOUNT;
                  end else begin
                     tidx_in = tidx_ff + 3'd1;
                  end
               end
               crd_pkg::PH_HCOUNT: begin
                  hcount_in = acc[31:0];
                  hdrs_in   = acc[31:0];
                  phase_in  = (acc[31:0] != 32'd0) ? crd_pkg::PH_NAMELEN : crd_pkg::PH_BODYLEN;
               end
               crd_pkg::PH_NAMELEN: begin
                  left_in  = {32'd0, acc[31:0]};
                  phase_in = (acc[31:0] != 32'd0) ? crd_pkg::PH_NAME : crd_pkg::PH_VALLEN;
               end
               crd_pkg::PH_VALLEN: begin
                  left_in = {32'd0, acc[31:0]};
                  if (acc[31:0] != 32'd0) begin
                     phase_in = crd_pkg::PH_VALUE;
                  end else begin
                     hdrs_in  = hdrs_ff - 32'd1;
                     phase_in = (hdrs_ff != 32'd1) ? crd_pkg::PH_NAMELEN : crd_pkg::PH_BODYLEN;
                  end
               end
               crd_pkg::PH_BODYLEN: begin
                  left_in  = acc;
                  phase_in = (acc != 64'd0) ? crd_pkg::PH_BODY : crd_pkg::PH_TRAILER;
               end
               crd_pkg::PH_TRAILER: begin
                  if (acc != hash_ff) err_in = crd_pkg::ERR_SUM;
                  phase_in = crd_pkg::PH_AFTER;
               end
               default: begin
               end
            endcase
         end
      end

      // record ends before the trailer is through
      if (err_in == crd_pkg::ERR_NONE && phase_in != crd_pkg::PH_AFTER) begin
         err_final = crd_pkg::ERR_SHORT;
      end else begin
         err_final = err_in;
      end

      result           = '0;
      result.data_byte = in_byte;
      result.region    = region;
      if (in_last) begin
         result.record_done            = 1'b1;
         result.record_ok              = (err_final == crd_pkg::ERR_NONE);
         result.fault_code             = err_final;
         result.http_status            = status_in;
         result.stored_at              = stored_in;
         result.initial_age            = age_in;
         result.expires_at             = expires_in;
         result.stale_while_revalidate = swr_in;
         result.stale_if_error         = sie_in;
         result.header_count           = hcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && in_last)) begin
         phase_ff   <= crd_pkg::PH_MAGIC;
         bif_ff     <= 3'd0;
         shift_ff   <= 64'd0;
         left_ff    <= 64'd0;
         hdrs_ff    <= 32'd0;
         tidx_ff    <= 3'd0;
         hash_ff    <= crd_pkg::HASH_BASIS;
         err_ff     <= crd_pkg::ERR_NONE;
         status_ff  <= 16'd0;
         stored_ff  <= 64'd0;
         age_ff     <= 64'd0;
         expires_ff <= 64'd0;
         swr_ff     <= 64'd0;
         sie_ff     <= 64'd0;
         hcount_ff  <= 32'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         bif_ff     <= bif_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         hdrs_ff    <= hdrs_in;
         tidx_ff    <= tidx_in;
         hash_ff    <= hash_in;
         err_ff     <= err_in;
         status_ff  <= status_in;
         stored_ff  <= stored_in;
         age_ff     <= age_in;
         expires_ff <= expires_in;
         swr_ff     <= swr_in;
         sie_ff     <= sie_in;
         hcount_ff  <= hcount_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cache_record_deframer.sv @@
// Cached-response record deframer.
// req_* takes the serialized record one byte per transfer, req_tlast on its final byte.
// rsp_* returns one result per input byte: the echoed byte, its region tag in rsp_tuser,
// and on the record's last byte (rsp_tlast) the verdict and the decoded fixed fields.
// Every byte is hashed with 64-bit FNV-1a up to the 8-byte trailer, which must match.
// A result passes through the input register, then the parse logic, then the result
// register before it is offered on rsp.
// Throughput: one byte per clock while rsp_tready is high; the hash step is a constant
// multiply built from adds inside the parse stage, so bytes may arrive back to back.
// Reset (synchronous, active high) empties both registers, holds req_tready low and
// returns the parser to the start of a record; after each record's last byte the parser
// returns there by itself.
// When rsp_tready is low and a result is waiting, the result register holds. A byte
// already waiting in the input register stays there and req_tready drops in that same
// cycle; an empty input register still takes one more byte first.
`default_nettype none

module cache_record_deframer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] in_byte
   input  wire logic         req_tlast,   // in_last
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [7:0] data_byte, [8] record_ok, [11:9] fault_code, [27:12] http_status,
   // [91:28] stored_at, [155:92] initial_age, [219:156] expires_at,
   // [283:220] stale_while_revalidate, [347:284] stale_if_error,
   // [379:348] header_count, [383:380] zero
   output logic [383:0]      rsp_tdata,
   output logic [2:0]        rsp_tuser,   // [2:0] region
   output logic              rsp_tlast    // record_done
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   logic                 rsp_valid_ff;
   crd_pkg::result_type  rsp_ff;
   crd_pkg::result_type  result_in;

   // byte moves from input register to result register when the result slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   crd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.region;
   assign rsp_tlast  = rsp_ff.record_done;
   assign rsp_tdata  = {4'd0, rsp_ff.header_count, rsp_ff.stale_if_error,
                        rsp_ff.stale_while_revalidate, rsp_ff.expires_at,
                        rsp_ff.initial_age, rsp_ff.stored_at, rsp_ff.http_status,
                        rsp_ff.fault_code, rsp_ff.record_ok, rsp_ff.data_byte};

   // verdict fields only on the closing result
   a_no_verdict_midrecord: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_ff.fault_code == crd_pkg::ERR_NONE && !rsp_ff.record_ok))
      else $error("verdict on a result that does not close a record");

   // ok flag agrees with the error code
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_ff.record_ok == (rsp_ff.fault_code == crd_pkg::ERR_NONE)))
      else $error("record_ok disagrees with fault_code");

   // a blocked byte stays put in the input register
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("input register lost or changed a pending byte");

endmodule

`default_nettype wire
